### sv/assert_macros.svh
// Assertion helpers included by the BSDF top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, off while reset is asserted.
`define ASSERT_AR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must hold while the enable is low.
`define ASSERT_HOLD(lbl, clk, rst_n, en, sig, msg) \
  `ASSERT_AR(lbl, clk, rst_n, (!(en)) |=> $stable(sig), msg)

`endif

### sv/ggx_pkg.sv
// ----------------------------------------------------------------------------
// ggx_pkg
// Shared types, fixed-point constants and helpers of the GGX BSDF pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ggx_pkg;

  localparam int FXB = 28;           // internal fraction bits
  localparam int VW  = 48;           // internal signed value width
  localparam int HW  = VW / 2;       // partial product split
  localparam int PW  = 2 * VW;       // full product width

  localparam int VEC_FRAC_BITS_DEF = 14;
  localparam int OUT_FRAC_BITS_DEF = 16;

  localparam int SAT_EXP      = 44;
  localparam int PROD_LIM_EXP = 62;

  typedef logic signed [VW-1:0] sval_t;

  typedef struct packed {
    logic  ovf;
    sval_t v;
  } val_t;

  localparam sval_t ONE_Q     = sval_t'(1) <<< FXB;
  localparam sval_t SAT_Q     = sval_t'(1) <<< SAT_EXP;
  localparam sval_t QUARTER_Q = sval_t'(1) <<< (FXB - 2);
  localparam sval_t PI_Q      = sval_t'(843314857);
  localparam sval_t INV_PI_Q  = sval_t'(85445659);

  // configuration registers
  localparam int CFG_W     = 16;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);

  typedef logic [CFG_W-1:0] cfg_t;

  localparam logic [CFG_IDX_W-1:0] REG_ROUGHNESS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_F0_RED    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_METALNESS = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ALB_RED   = CFG_IDX_W'(5);

  localparam cfg_t REG_RESET [NUM_REGS] = '{
    16'd32768, 16'd2621, 16'd2621, 16'd2621, 16'd0, 16'd52429, 16'd52429, 16'd52429
  };

  // divider geometry
  localparam int DIV_NUM_W  = FXB + 1;
  localparam int DIV_DVD_W  = DIV_NUM_W + FXB;
  localparam int DIV_BPS    = 4;
  localparam int DIV_STAGES = (DIV_DVD_W + DIV_BPS - 1) / DIV_BPS;
  localparam int DIV_PAD_W  = DIV_STAGES * DIV_BPS;
  localparam int DIV_LAT    = DIV_STAGES + 2;
  localparam int MUL_LAT    = 2;

  function automatic val_t mkv(input sval_t x);
    val_t r;
    r.ovf = 1'b0;
    r.v   = x;
    return r;
  endfunction

  // unsigned Q0.16 register to internal format
  function automatic sval_t q16(input cfg_t x);
    return sval_t'({x, {(FXB - CFG_W){1'b0}}});
  endfunction

  function automatic val_t vadd(input val_t a, input sval_t b);
    val_t r;
    r.ovf = a.ovf;
    r.v   = a.v + b;
    return r;
  endfunction

  function automatic val_t vsub(input sval_t c, input val_t a);
    val_t r;
    r.ovf = a.ovf;
    r.v   = c - a.v;
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/ggx_if.sv
// ----------------------------------------------------------------------------
// ggx_if
// Valid/ready channels carrying one shading sample and one BSDF result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ggx_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_dir_x;
  logic signed [15:0] out_dir_y;
  logic signed [15:0] out_dir_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [15:0] in_dir_x;
  logic signed [15:0] in_dir_y;
  logic signed [15:0] in_dir_z;
  logic signed [15:0] half_x;
  logic signed [15:0] half_y;
  logic signed [15:0] half_z;

  modport source (
    output valid, out_dir_x, out_dir_y, out_dir_z, normal_x, normal_y, normal_z,
           in_dir_x, in_dir_y, in_dir_z, half_x, half_y, half_z,
    input  ready
  );
  modport sink (
    input  valid, out_dir_x, out_dir_y, out_dir_z, normal_x, normal_y, normal_z,
           in_dir_x, in_dir_y, in_dir_z, half_x, half_y, half_z,
    output ready
  );
endinterface

interface ggx_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] bsdf_red;
  logic signed [31:0] bsdf_green;
  logic signed [31:0] bsdf_blue;
  logic               overflow_flag;

  modport source (
    output valid, bsdf_red, bsdf_green, bsdf_blue, overflow_flag,
    input  ready
  );
  modport sink (
    input  valid, bsdf_red, bsdf_green, bsdf_blue, overflow_flag,
    output ready
  );
endinterface

`default_nettype wire

### sv/ggx_dly.sv
// ----------------------------------------------------------------------------
// ggx_dly
// Enabled delay line that keeps side values aligned with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ggx_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[N-1];

endmodule

`default_nettype wire

### sv/ggx_mul.sv
// ----------------------------------------------------------------------------
// ggx_mul
// Two-stage saturating fixed-point multiply: split partial products, then
// combine, truncate toward zero and clamp at 2^16.
// ----------------------------------------------------------------------------
`default_nettype none

module ggx_mul (
  input  logic          clk_i,
  input  logic          en_i,
  input  ggx_pkg::val_t a_i,
  input  ggx_pkg::val_t b_i,
  output ggx_pkg::val_t p_o
);

  localparam int VW = ggx_pkg::VW;
  localparam int HW = ggx_pkg::HW;
  localparam int PW = ggx_pkg::PW;

  logic [VW-1:0] amag, bmag;
  logic [VW-1:0] pp_ll_d, pp_lh_d, pp_hl_d, pp_hh_d;
  logic [VW-1:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic          neg_q, ovf_q;
  logic [PW-1:0] prod;
  logic          big;
  logic [VW-1:0] mag;
  ggx_pkg::val_t p_d, p_q;

  always_comb begin
    amag    = a_i.v[VW-1] ? $unsigned(-a_i.v) : $unsigned(a_i.v);
    bmag    = b_i.v[VW-1] ? $unsigned(-b_i.v) : $unsigned(b_i.v);
    pp_ll_d = amag[HW-1:0]  * bmag[HW-1:0];
    pp_lh_d = amag[HW-1:0]  * bmag[VW-1:HW];
    pp_hl_d = amag[VW-1:HW] * bmag[HW-1:0];
    pp_hh_d = amag[VW-1:HW] * bmag[VW-1:HW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q <= pp_ll_d;
      pp_lh_q <= pp_lh_d;
      pp_hl_q <= pp_hl_d;
      pp_hh_q <= pp_hh_d;
      neg_q   <= a_i.v[VW-1] ^ b_i.v[VW-1];
      ovf_q   <= a_i.ovf | b_i.ovf;
    end
  end

  // a product above 2^62 always ends up clamped
  always_comb begin
    prod  = {pp_hh_q, {VW{1'b0}}} + (PW'(pp_hl_q) << HW) + (PW'(pp_lh_q) << HW)
          + PW'(pp_ll_q);
    big   = prod > (PW'(1) << ggx_pkg::PROD_LIM_EXP);
    mag   = big ? $unsigned(ggx_pkg::SAT_Q) : prod[ggx_pkg::FXB +: VW];
    p_d.ovf = ovf_q | big;
    p_d.v   = neg_q ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### sv/ggx_div.sv
// ----------------------------------------------------------------------------
// ggx_div
// Pipelined restoring divider, (num << 28) / den, several quotient bits per
// stage, with clamp at 2^16 and zero-divisor handling.
// ----------------------------------------------------------------------------
`default_nettype none

module ggx_div (
  input  logic          clk_i,
  input  logic          en_i,
  input  ggx_pkg::val_t num_i,
  input  ggx_pkg::val_t den_i,
  output ggx_pkg::val_t q_o
);

  localparam int VW    = ggx_pkg::VW;
  localparam int NS    = ggx_pkg::DIV_STAGES;
  localparam int BPS   = ggx_pkg::DIV_BPS;
  localparam int PADW  = ggx_pkg::DIV_PAD_W;
  localparam int NUMW  = ggx_pkg::DIV_NUM_W;
  localparam int REM_W = VW + 1;

  logic [VW-1:0]    nmag, dmag;
  logic [REM_W-1:0] s_rem_q [NS+1];
  logic [PADW-1:0]  s_dvd_q [NS+1];
  logic [PADW-1:0]  s_quo_q [NS+1];
  logic [VW-1:0]    s_den_q [NS+1];
  logic             s_neg_q [NS+1];
  logic             s_dz_q  [NS+1];
  logic             s_ovf_q [NS+1];
  logic             sat;
  logic [VW-1:0]    qmag;
  ggx_pkg::val_t    q_d, q_q;

  always_comb begin
    nmag = num_i.v[VW-1] ? $unsigned(-num_i.v) : $unsigned(num_i.v);
    dmag = den_i.v[VW-1] ? $unsigned(-den_i.v) : $unsigned(den_i.v);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_rem_q[0] <= '0;
      s_dvd_q[0] <= PADW'({nmag[NUMW-1:0], {ggx_pkg::FXB{1'b0}}});
      s_quo_q[0] <= '0;
      s_den_q[0] <= dmag;
      s_neg_q[0] <= num_i.v[VW-1] ^ den_i.v[VW-1];
      s_dz_q[0]  <= (den_i.v == '0);
      s_ovf_q[0] <= num_i.ovf | den_i.ovf;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [REM_W-1:0] rem_d;
    logic [PADW-1:0]  dvd_d, quo_d;

    always_comb begin
      rem_d = s_rem_q[i];
      dvd_d = s_dvd_q[i];
      quo_d = s_quo_q[i];
      for (int b = 0; b < BPS; b++) begin
        rem_d = {rem_d[REM_W-2:0], dvd_d[PADW-1]};
        dvd_d = dvd_d << 1;
        if (rem_d >= {1'b0, s_den_q[i]}) begin
          rem_d = rem_d - {1'b0, s_den_q[i]};
          quo_d = {quo_d[PADW-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[PADW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_rem_q[i+1] <= rem_d;
        s_dvd_q[i+1] <= dvd_d;
        s_quo_q[i+1] <= quo_d;
        s_den_q[i+1] <= s_den_q[i];
        s_neg_q[i+1] <= s_neg_q[i];
        s_dz_q[i+1]  <= s_dz_q[i];
        s_ovf_q[i+1] <= s_ovf_q[i];
      end
    end
  end

  // zero divisor gives +2^16 regardless of signs
  always_comb begin
    sat     = s_dz_q[NS] || (s_quo_q[NS] > PADW'($unsigned(ggx_pkg::SAT_Q)));
    qmag    = sat ? $unsigned(ggx_pkg::SAT_Q) : s_quo_q[NS][VW-1:0];
    q_d.ovf = s_ovf_q[NS] | sat;
    q_d.v   = (s_neg_q[NS] && !s_dz_q[NS]) ? -$signed(qmag) : $signed(qmag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

### sv/ggx_microfacet_bsdf_evaluate.sv
// Throughput: one item per cycle; the whole pipeline stalls only when the
// result register holds an item that is not taken. The depth is set by the
// chain of two-stage multipliers and the divider for the D term. Reset clears
// the valid bits and loads the material registers with their defaults.
// ----------------------------------------------------------------------------
// ggx_microfacet_bsdf_evaluate
// Cook-Torrance BSDF with GGX D, Schlick G and Schlick Fresnel, RGB output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ggx_microfacet_bsdf_evaluate #(
  parameter int VEC_FRAC_BITS = ggx_pkg::VEC_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = ggx_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ggx_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ggx_pkg::CFG_W-1:0]     cfg_data_i,
  ggx_in_if.sink                        in_i,
  ggx_out_if.source                     out_o
);

  localparam int VW      = ggx_pkg::VW;
  localparam int FXB     = ggx_pkg::FXB;
  localparam int DL      = ggx_pkg::DIV_LAT;
  localparam int NLVL    = 16 + DL;
  localparam int VAL_W   = $bits(ggx_pkg::val_t);
  localparam int DOT_LSH = (FXB >= 2 * VEC_FRAC_BITS) ? FXB - 2 * VEC_FRAC_BITS : 0;
  localparam int DOT_RSH = (2 * VEC_FRAC_BITS > FXB) ? 2 * VEC_FRAC_BITS - FXB : 0;
  localparam int OUT_SH  = FXB - OUT_FRAC_BITS;
  localparam logic signed [VW:0] R_MAX = (VW+1)'(2147483647);
  localparam logic signed [VW:0] R_MIN = -R_MAX - 1;

  logic                en, acc;
  logic [NLVL-1:0]     vld_q;
  ggx_pkg::cfg_t       cfg_q [ggx_pkg::NUM_REGS];

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ggx_pkg::NUM_REGS; i++) begin
        cfg_q[i] <= ggx_pkg::REG_RESET[i];
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // ---------------- flow control ----------------
  assign en         = !vld_q[NLVL-1] || out_o.ready;
  assign acc        = in_i.valid && en;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NLVL-2:0], acc};
    end
  end

  // ---------------- dot products ----------------
  function automatic ggx_pkg::sval_t dot3(
    input logic signed [15:0] a0, a1, a2,
    input logic signed [15:0] b0, b1, b2
  );
    logic signed [33:0] s;
    logic [VW-1:0]      m, r;
    s = a0 * b0 + a1 * b1 + a2 * b2;
    m = s[33] ? VW'($unsigned(-s)) : VW'($unsigned(s));
    r = (m << DOT_LSH) >> DOT_RSH;
    return s[33] ? -$signed(r) : $signed(r);
  endfunction

  ggx_pkg::val_t  co_q, ci_q, ch_q, cf_q;
  ggx_pkg::sval_t cf_raw;

  assign cf_raw = dot3(in_i.out_dir_x, in_i.out_dir_y, in_i.out_dir_z,
                       in_i.half_x, in_i.half_y, in_i.half_z);

  always_ff @(posedge clk_i) begin
    if (en) begin
      co_q <= ggx_pkg::mkv(dot3(in_i.normal_x, in_i.normal_y, in_i.normal_z,
                                in_i.out_dir_x, in_i.out_dir_y, in_i.out_dir_z));
      ci_q <= ggx_pkg::mkv(dot3(in_i.normal_x, in_i.normal_y, in_i.normal_z,
                                in_i.in_dir_x, in_i.in_dir_y, in_i.in_dir_z));
      ch_q <= ggx_pkg::mkv(dot3(in_i.normal_x, in_i.normal_y, in_i.normal_z,
                                in_i.half_x, in_i.half_y, in_i.half_z));
      cf_q <= ggx_pkg::mkv(cf_raw[VW-1] ? '0 : cf_raw);  // Fresnel cosine clamp
    end
  end

  // ---------------- material terms ----------------
  ggx_pkg::sval_t a_v, k_v, omm_v;
  ggx_pkg::val_t  a_c, omk_c;

  assign a_v   = ggx_pkg::q16(cfg_q[ggx_pkg::REG_ROUGHNESS]);
  assign k_v   = a_v >>> 1;
  assign omm_v = ggx_pkg::ONE_Q - ggx_pkg::q16(cfg_q[ggx_pkg::REG_METALNESS]);
  assign a_c   = ggx_pkg::mkv(a_v);
  assign omk_c = ggx_pkg::mkv(ggx_pkg::ONE_Q - k_v);

  // ---------------- level 1 -> 3 ----------------
  ggx_pkg::val_t u_l1, c2, a2, g1i_m, g1o_m, u2;

  assign u_l1 = ggx_pkg::vsub(ggx_pkg::ONE_Q, cf_q);

  ggx_mul u_m_c2  (.clk_i, .en_i(en), .a_i(ch_q), .b_i(ch_q),  .p_o(c2));
  ggx_mul u_m_a2  (.clk_i, .en_i(en), .a_i(a_c),  .b_i(a_c),   .p_o(a2));
  ggx_mul u_m_g1i (.clk_i, .en_i(en), .a_i(ci_q), .b_i(omk_c), .p_o(g1i_m));
  ggx_mul u_m_g1o (.clk_i, .en_i(en), .a_i(co_q), .b_i(omk_c), .p_o(g1o_m));
  ggx_mul u_m_u2  (.clk_i, .en_i(en), .a_i(u_l1), .b_i(u_l1),  .p_o(u2));

  ggx_pkg::val_t u_l5;
  ggx_dly #(.W(VAL_W), .N(4)) u_d_u (.clk_i, .en_i(en), .d_i(u_l1), .q_o(u_l5));

  // ---------------- level 3 -> 5 ----------------
  ggx_pkg::val_t a2m1, g1i, g1o, m6, gden, u4, a2_l9;

  assign a2m1 = ggx_pkg::vadd(a2, -ggx_pkg::ONE_Q);
  assign g1i  = ggx_pkg::vadd(g1i_m, k_v);
  assign g1o  = ggx_pkg::vadd(g1o_m, k_v);

  ggx_mul u_m_t   (.clk_i, .en_i(en), .a_i(c2),  .b_i(a2m1), .p_o(m6));
  ggx_mul u_m_gd  (.clk_i, .en_i(en), .a_i(g1i), .b_i(g1o),  .p_o(gden));
  ggx_mul u_m_u4  (.clk_i, .en_i(en), .a_i(u2),  .b_i(u2),   .p_o(u4));

  ggx_dly #(.W(VAL_W), .N(6)) u_d_a2 (.clk_i, .en_i(en), .d_i(a2), .q_o(a2_l9));

  // ---------------- level 5 -> 7 ----------------
  ggx_pkg::val_t t_v, tt, u5, g_q5, g_l9;

  assign t_v = ggx_pkg::vadd(m6, ggx_pkg::ONE_Q);

  ggx_mul u_m_tt  (.clk_i, .en_i(en), .a_i(t_v), .b_i(t_v),  .p_o(tt));
  ggx_mul u_m_u5  (.clk_i, .en_i(en), .a_i(u4),  .b_i(u_l5), .p_o(u5));

  ggx_div u_div_g (.clk_i, .en_i(en), .num_i(ggx_pkg::mkv(ggx_pkg::ONE_Q)),
                   .den_i(gden), .q_o(g_q5));
  ggx_dly #(.W(VAL_W), .N(4)) u_d_g (.clk_i, .en_i(en), .d_i(g_q5), .q_o(g_l9));

  // ---------------- level 7 -> 9, D divide ----------------
  ggx_pkg::val_t dden, d_v, dg1, dg;

  ggx_mul u_m_den (.clk_i, .en_i(en), .a_i(ggx_pkg::mkv(ggx_pkg::PI_Q)), .b_i(tt),
                   .p_o(dden));
  ggx_div u_div_d (.clk_i, .en_i(en), .num_i(a2_l9), .den_i(dden), .q_o(d_v));

  ggx_mul u_m_dg1 (.clk_i, .en_i(en), .a_i(d_v), .b_i(g_l9), .p_o(dg1));
  ggx_mul u_m_dg  (.clk_i, .en_i(en), .a_i(dg1),
                   .b_i(ggx_pkg::mkv(ggx_pkg::QUARTER_Q)), .p_o(dg));

  // ---------------- per channel ----------------
  ggx_pkg::val_t diff [3];
  ggx_pkg::val_t spec [3];

  for (genvar c = 0; c < 3; c++) begin : g_ch
    ggx_pkg::sval_t f0_v, alb_v;
    ggx_pkg::val_t  fm, f_v, kd, dm, df, f_d;

    assign f0_v  = ggx_pkg::q16(cfg_q[ggx_pkg::REG_F0_RED + ggx_pkg::CFG_IDX_W'(c)]);
    assign alb_v = ggx_pkg::q16(cfg_q[ggx_pkg::REG_ALB_RED + ggx_pkg::CFG_IDX_W'(c)]);

    ggx_mul u_m_fm (.clk_i, .en_i(en), .a_i(ggx_pkg::mkv(ggx_pkg::ONE_Q - f0_v)),
                    .b_i(u5), .p_o(fm));
    assign f_v = ggx_pkg::vadd(fm, f0_v);

    ggx_mul u_m_kd (.clk_i, .en_i(en), .a_i(ggx_pkg::vsub(ggx_pkg::ONE_Q, f_v)),
                    .b_i(ggx_pkg::mkv(omm_v)), .p_o(kd));
    ggx_mul u_m_dm (.clk_i, .en_i(en), .a_i(ggx_pkg::mkv(alb_v)), .b_i(kd), .p_o(dm));
    ggx_mul u_m_df (.clk_i, .en_i(en), .a_i(dm),
                    .b_i(ggx_pkg::mkv(ggx_pkg::INV_PI_Q)), .p_o(df));
    ggx_dly #(.W(VAL_W), .N(DL)) u_d_df (.clk_i, .en_i(en), .d_i(df), .q_o(diff[c]));

    ggx_dly #(.W(VAL_W), .N(4 + DL)) u_d_f (.clk_i, .en_i(en), .d_i(f_v), .q_o(f_d));
    ggx_mul u_m_sp (.clk_i, .en_i(en), .a_i(dg), .b_i(f_d), .p_o(spec[c]));
  end

  // ---------------- output rescale and clamp ----------------
  logic signed [31:0] bsdf_d [3];
  logic signed [31:0] bsdf_q [3];
  logic               ovf_d, ovf_q;

  always_comb begin
    logic signed [VW:0] sum, r;
    logic [VW:0]        mag;
    logic               hi, lo;
    ovf_d = 1'b0;
    for (int c = 0; c < 3; c++) begin
      sum = (VW+1)'(diff[c].v) + (VW+1)'(spec[c].v);
      mag = sum[VW] ? $unsigned(-sum) : $unsigned(sum);
      mag = mag >> OUT_SH;
      r   = sum[VW] ? -$signed(mag) : $signed(mag);
      hi  = r > R_MAX;
      lo  = r < R_MIN;
      bsdf_d[c] = hi ? 32'sh7FFF_FFFF : (lo ? 32'sh8000_0000 : r[31:0]);
      ovf_d = ovf_d | hi | lo | diff[c].ovf | spec[c].ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bsdf_q <= bsdf_d;
      ovf_q  <= ovf_d;
    end
  end

  assign out_o.valid         = vld_q[NLVL-1];
  assign out_o.bsdf_red      = bsdf_q[0];
  assign out_o.bsdf_green    = bsdf_q[1];
  assign out_o.bsdf_blue     = bsdf_q[2];
  assign out_o.overflow_flag = ovf_q;

  // ---------------- assertions ----------------
  `ASSERT_AR(a_acc_enters, clk_i, rst_ni, acc |=> vld_q[0],
             "accepted item not in first stage")
  `ASSERT_AR(a_vld_shift, clk_i, rst_ni,
             en |=> (vld_q[NLVL-1:1] == $past(vld_q[NLVL-2:0])),
             "item valid lost between stages")
  `ASSERT_HOLD(a_stall_hold, clk_i, rst_ni, en, vld_q, "pipeline moved during stall")

endmodule

`default_nettype wire

### tb/sv/ggx_microfacet_bsdf_evaluate_test.sv
// ----------------------------------------------------------------------------
// ggx_microfacet_bsdf_evaluate_test
// Self-checking bench for the GGX BSDF pipeline. A fixed-point model of the
// shading math predicts every result; directed corner samples open the first
// two phases, and random samples follow over several material settings and flow-control modes.
// ----------------------------------------------------------------------------
`default_nettype none

module ggx_microfacet_bsdf_evaluate_test;

  localparam int  DRAIN_CYCLES = 40;     // pipeline is 33 deep
  localparam int  STALL_LIMIT  = 5000;
  localparam int  PHASES       = 6;
  localparam int  RAND_ITEMS   = 192;    // per phase
  localparam int  HOLD_CYCLES  = 300;
  localparam longint FX_ONE    = longint'(1) << 28;
  localparam longint FX_SAT    = longint'(1) << 44;
  localparam longint FX_PI     = 843314857;
  localparam longint FX_INVPI  = 85445659;
  localparam longint FX_QUART  = longint'(1) << 26;

  typedef logic signed [15:0] comp_t;
  typedef comp_t sample_t [12];
  typedef struct {
    logic signed [31:0] red;
    logic signed [31:0] green;
    logic signed [31:0] blue;
    logic               ovf;
  } bsdf_t;

  // wo, n, wi, wh
  localparam int NDIR = 14;
  localparam comp_t DIR_TABLE [NDIR][12] = '{
    '{0, 0, 0,  0, 0, 0,  0, 0, 0,  0, 0, 0},
    '{0, 0, 16384,  0, 0, 16384,  0, 0, 16384,  0, 0, 16384},
    '{0, 0, -16384,  0, 0, 16384,  0, 0, -16384,  0, 0, -16384},
    '{16384, 0, 0,  0, 0, 16384,  -16384, 0, 0,  0, 0, 16384},
    '{0, 16384, 0,  0, 16384, 0,  0, 16384, 0,  0, -16384, 0},
    '{16384, 16384, 16384,  16384, 16384, 16384,  16384, 16384, 16384,
      16384, 16384, 16384},
    '{-16384, -16384, -16384,  -16384, -16384, -16384,  -16384, -16384, -16384,
      -16384, -16384, -16384},
    '{32767, 32767, 32767,  32767, 32767, 32767,  32767, 32767, 32767,
      32767, 32767, 32767},
    '{-32768, -32768, -32768,  -32768, -32768, -32768,  -32768, -32768, -32768,
      -32768, -32768, -32768},
    '{-32768, 32767, -32768,  32767, -32768, 32767,  -32768, 32767, -32768,
      32767, -32768, 32767},
    '{11585, 0, 11585,  0, 0, 16384,  -11585, 0, 11585,  0, 0, 16384},
    '{0, 0, 16384,  0, 0, 16384,  0, 0, 0,  0, 0, 16384},
    '{0, 0, 16384,  0, 0, 16384,  16384, 0, 0,  0, 0, -16384},
    '{-1, -1, -1,  1, 1, 1,  -1, 1, -1,  -1, -1, -1}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ggx_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [ggx_pkg::CFG_W-1:0] cfg_data_i = '0;

  ggx_in_if  in_ch();
  ggx_out_if out_ch();

  ggx_microfacet_bsdf_evaluate DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  ggx_pkg::cfg_t material [ggx_pkg::NUM_REGS];
  bsdf_t pending_bsdf [$];
  int    errors = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_left = 0;
  int    quiet_cycles = 0;

  // ---------------------------------------------------------------- predictor
  function automatic longint fx_sign(longint unsigned mag, bit neg);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned fx_abs(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint fx_mul(longint x, longint y, inout bit ovf);
    longint unsigned ax, ay, p;
    bit neg;
    ax  = fx_abs(x);
    ay  = fx_abs(y);
    neg = (x < 0) != (y < 0);
    if (ax != 0 && ay > ((64'd1 << 62) / ax)) begin
      ovf = 1'b1;
      return fx_sign(FX_SAT, neg);
    end
    p = (ax * ay) >> 28;
    if (p > FX_SAT) begin
      ovf = 1'b1;
      p = FX_SAT;
    end
    return fx_sign(p, neg);
  endfunction

  function automatic longint fx_div(longint num, longint den, inout bit ovf);
    longint unsigned q;
    if (den == 0) begin
      ovf = 1'b1;
      return FX_SAT;
    end
    q = (fx_abs(num) << 28) / fx_abs(den);
    if (q > FX_SAT) begin
      ovf = 1'b1;
      q = FX_SAT;
    end
    return fx_sign(q, (num < 0) != (den < 0));
  endfunction

  // Q2.14 times Q2.14 already lands on 28 fraction bits
  function automatic longint fx_dot(sample_t s, int a, int b);
    return longint'(s[a]) * s[b] + longint'(s[a+1]) * s[b+1] + longint'(s[a+2]) * s[b+2];
  endfunction

  function automatic bsdf_t eval_bsdf(sample_t s);
    longint c_o, c_i, c_h, c_f, a, a2, k, c2, t, den, d, g1i, g1o, g, dg;
    longint u, u2, u5, kd_m, f0, alb, f, kd, diff, spec, r;
    longint res [3];
    bit ovf;
    bsdf_t e;
    ovf = 1'b0;
    c_o = fx_dot(s, 3, 0);
    c_i = fx_dot(s, 3, 6);
    c_h = fx_dot(s, 3, 9);
    c_f = fx_dot(s, 0, 9);
    if (c_f < 0) c_f = 0;
    a   = longint'(material[ggx_pkg::REG_ROUGHNESS]) << 12;
    a2  = fx_mul(a, a, ovf);
    c2  = fx_mul(c_h, c_h, ovf);
    t   = fx_mul(c2, a2 - FX_ONE, ovf) + FX_ONE;
    den = fx_mul(FX_PI, fx_mul(t, t, ovf), ovf);
    d   = fx_div(a2, den, ovf);
    k   = a >>> 1;
    g1i = fx_mul(c_i, FX_ONE - k, ovf) + k;
    g1o = fx_mul(c_o, FX_ONE - k, ovf) + k;
    g   = fx_div(FX_ONE, fx_mul(g1i, g1o, ovf), ovf);
    dg  = fx_mul(fx_mul(d, g, ovf), FX_QUART, ovf);
    u   = FX_ONE - c_f;
    u2  = fx_mul(u, u, ovf);
    u5  = fx_mul(fx_mul(u2, u2, ovf), u, ovf);
    kd_m = FX_ONE - (longint'(material[ggx_pkg::REG_METALNESS]) << 12);
    for (int ch = 0; ch < 3; ch++) begin
      f0   = longint'(material[ggx_pkg::REG_F0_RED + ch]) << 12;
      alb  = longint'(material[ggx_pkg::REG_ALB_RED + ch]) << 12;
      f    = f0 + fx_mul(FX_ONE - f0, u5, ovf);
      kd   = fx_mul(FX_ONE - f, kd_m, ovf);
      diff = fx_mul(fx_mul(alb, kd, ovf), FX_INVPI, ovf);
      spec = fx_mul(dg, f, ovf);
      r    = fx_sign(fx_abs(diff + spec) >> 12, (diff + spec) < 0);
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647;
        ovf = 1'b1;
      end else if (r < -64'sd2147483648) begin
        r = -64'sd2147483648;
        ovf = 1'b1;
      end
      res[ch] = r;
    end
    e.red   = res[0][31:0];
    e.green = res[1][31:0];
    e.blue  = res[2][31:0];
    e.ovf   = ovf;
    return e;
  endfunction

  // ------------------------------------------------------------- monitoring
  always @(posedge clk_i) begin
    sample_t s;
    bsdf_t   e;
    bit      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        s = '{in_ch.out_dir_x, in_ch.out_dir_y, in_ch.out_dir_z,
              in_ch.normal_x, in_ch.normal_y, in_ch.normal_z,
              in_ch.in_dir_x, in_ch.in_dir_y, in_ch.in_dir_z,
              in_ch.half_x, in_ch.half_y, in_ch.half_z};
        pending_bsdf.push_back(eval_bsdf(s));
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (pending_bsdf.size() == 0) begin
          errors++;
          $display("%0t: unexpected item red=%0d green=%0d blue=%0d ovf=%0b", $time,
                   out_ch.bsdf_red, out_ch.bsdf_green, out_ch.bsdf_blue,
                   out_ch.overflow_flag);
        end else begin
          e = pending_bsdf.pop_front();
          if (out_ch.bsdf_red !== e.red) begin
            errors++;
            $display("%0t: bsdf_red expected %0d actual %0d", $time, e.red, out_ch.bsdf_red);
          end
          if (out_ch.bsdf_green !== e.green) begin
            errors++;
            $display("%0t: bsdf_green expected %0d actual %0d", $time, e.green,
                     out_ch.bsdf_green);
          end
          if (out_ch.bsdf_blue !== e.blue) begin
            errors++;
            $display("%0t: bsdf_blue expected %0d actual %0d", $time, e.blue,
                     out_ch.bsdf_blue);
          end
          if (out_ch.overflow_flag !== e.ovf) begin
            errors++;
            $display("%0t: overflow_flag expected %0b actual %0b", $time, e.ovf,
                     out_ch.overflow_flag);
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[ggx_microfacet_bsdf_evaluate] ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus
  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input logic [ggx_pkg::CFG_IDX_W-1:0] idx,
                           input ggx_pkg::cfg_t val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    material[idx] = val;
    @(negedge clk_i);
  endtask

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.out_dir_x <= s[0];  in_ch.out_dir_y <= s[1];  in_ch.out_dir_z <= s[2];
    in_ch.normal_x  <= s[3];  in_ch.normal_y  <= s[4];  in_ch.normal_z  <= s[5];
    in_ch.in_dir_x  <= s[6];  in_ch.in_dir_y  <= s[7];  in_ch.in_dir_z  <= s[8];
    in_ch.half_x    <= s[9];  in_ch.half_y    <= s[10]; in_ch.half_z    <= s[11];
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic unit_dir(output real x, output real y, output real z);
    real n;
    do begin
      x = real'($urandom_range(2000)) - 1000.0;
      y = real'($urandom_range(2000)) - 1000.0;
      z = real'($urandom_range(2000)) - 1000.0;
      n = $sqrt(x * x + y * y + z * z);
    end while (n < 50.0 || n > 1000.0);
    x = x / n;
    y = y / n;
    z = z / n;
  endtask

  function automatic comp_t to_q14(real v);
    return comp_t'($rtoi(v * 16384.0));
  endfunction

  task automatic random_sample(output sample_t s);
    real ox, oy, oz, nx, ny, nz, ix, iy, iz, hx, hy, hz, hn;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      // raw bit patterns
      foreach (s[i]) s[i] = comp_t'($urandom);
    end else if (pick < 20) begin
      foreach (s[i]) s[i] = comp_t'($urandom_range(32768) - 16384);
    end else begin
      unit_dir(nx, ny, nz);
      unit_dir(ox, oy, oz);
      unit_dir(ix, iy, iz);
      // mostly the upper hemisphere around the normal
      if ($urandom_range(9) < 8 && ox * nx + oy * ny + oz * nz < 0) begin
        ox = -ox; oy = -oy; oz = -oz;
      end
      if ($urandom_range(9) < 8 && ix * nx + iy * ny + iz * nz < 0) begin
        ix = -ix; iy = -iy; iz = -iz;
      end
      hx = ox + ix; hy = oy + iy; hz = oz + iz;
      hn = $sqrt(hx * hx + hy * hy + hz * hz);
      if (hn < 0.01 || $urandom_range(9) == 0) begin
        hx = nx; hy = ny; hz = nz;
      end else begin
        hx = hx / hn; hy = hy / hn; hz = hz / hn;
      end
      s = '{to_q14(ox), to_q14(oy), to_q14(oz), to_q14(nx), to_q14(ny), to_q14(nz),
            to_q14(ix), to_q14(iy), to_q14(iz), to_q14(hx), to_q14(hy), to_q14(hz)};
    end
  endtask

  task automatic drain;
    while (pending_bsdf.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    sample_t s;
    ggx_pkg::cfg_t setting [ggx_pkg::NUM_REGS];
    in_ch.valid = 1'b0;
    foreach (s[i]) s[i] = '0;
    {in_ch.out_dir_x, in_ch.out_dir_y, in_ch.out_dir_z} = '0;
    {in_ch.normal_x, in_ch.normal_y, in_ch.normal_z} = '0;
    {in_ch.in_dir_x, in_ch.in_dir_y, in_ch.in_dir_z} = '0;
    {in_ch.half_x, in_ch.half_y, in_ch.half_z} = '0;
    out_ch.ready = 1'b0;
    foreach (material[i]) material[i] = ggx_pkg::REG_RESET[i];
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: setting = ggx_pkg::REG_RESET;
        1: setting = '{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0};
        2: setting = '{16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        default: foreach (setting[i]) setting[i] = ggx_pkg::cfg_t'($urandom);
      endcase
      // the reset phase relies on the defaults loaded by reset
      if (ph != 0) begin
        for (int r = 0; r < ggx_pkg::NUM_REGS; r++) begin
          write_reg(ggx_pkg::CFG_IDX_W'(r), setting[r]);
        end
        cfg_we_i <= 1'b0;
      end
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      if (ph == PHASES - 1) begin
        send_idle_pct = 0;
        hold_left = HOLD_CYCLES;
      end
      if (ph < 2) begin
        for (int i = 0; i < NDIR; i++) begin
          foreach (s[j]) s[j] = DIR_TABLE[i][j];
          send_sample(s);
        end
      end
      for (int i = 0; i < RAND_ITEMS; i++) begin
        random_sample(s);
        send_sample(s);
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("[ggx_microfacet_bsdf_evaluate] OK");
    end else begin
      $display("[ggx_microfacet_bsdf_evaluate] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
